FILE: hw/rtl/rsa_pkg.sv
// shared types and codes for the reference-counted slot allocator
package rsa_pkg;

	// default sizes
	localparam int POOL_SLOTS_DEF = 8;
	localparam int COUNT_BITS_DEF = 8;

	// operation codes
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_ADDREF  = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_QUERY   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NOT_USED  = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	// command beat
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
	} cmd_t;

	// response beat
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] granted_slot;
		logic [7:0] count_after;
		logic       slot_freed;
		logic [3:0] slots_in_use;
	} rsp_t;

	// used-map update request
	typedef struct packed {
		logic alloc;
		logic free;
	} map_upd_t;

endpackage

FILE: hw/rtl/rsa_count_mem.sv
// reference count memory, one write and one registered read port
module rsa_count_mem #(
	parameter int DEPTH = rsa_pkg::POOL_SLOTS_DEF,
	parameter int WIDTH = rsa_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/rsa_free_map.sv
// used-slot bitmap, lowest free slot finder and used counter
module rsa_free_map #(
	parameter int POOL_SLOTS = rsa_pkg::POOL_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rsa_pkg::map_upd_t                   upd,
	input  logic [$clog2(POOL_SLOTS)-1:0]       upd_idx,
	input  logic [$clog2(POOL_SLOTS)-1:0]       chk_idx,
	output logic                                chk_used,
	output logic [$clog2(POOL_SLOTS)-1:0]       free_idx,
	output logic                                any_free,
	output logic [$clog2(POOL_SLOTS+1)-1:0]     used_q,
	output logic [$clog2(POOL_SLOTS+1)-1:0]     used_next
);

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int UW = $clog2(POOL_SLOTS + 1);

	logic [POOL_SLOTS-1:0] in_use_q;
	logic [UW-1:0]         used_cnt_q;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign chk_used = in_use_q[chk_idx];

	// used count after the pending update
	always_comb begin
		used_next = used_cnt_q;
		if (upd.alloc) begin
			used_next = used_cnt_q + UW'(1);
		end else if (upd.free) begin
			used_next = used_cnt_q - UW'(1);
		end
	end

	// bitmap and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			used_cnt_q <= '0;
		end else begin
			if (upd.alloc) begin
				in_use_q[upd_idx] <= 1'b1;
			end else if (upd.free) begin
				in_use_q[upd_idx] <= 1'b0;
			end
			used_cnt_q <= used_next;
		end
	end

	assign used_q = used_cnt_q;

`ifndef SYNTHESIS
	// counter tracks the bitmap
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == int'(used_cnt_q))
		else $error("used counter disagrees with bitmap");

	// allocate only takes a free slot
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		upd.alloc |-> !in_use_q[upd_idx])
		else $error("allocate on a used slot");

	// release only frees a used slot
	a_free_used: assert property (@(posedge clk) disable iff (!arst_n)
		upd.free |-> in_use_q[upd_idx])
		else $error("free on an unused slot");
`endif

endmodule

FILE: hw/rtl/refcounted_slot_allocator.sv
// top level: command sequencing and count read-modify-write
//
// channel   dir  handshake                      payload
// command   in   start, taken when busy is low  cmd  (kind, slot)
// response  out  done strobe, one cycle         rsp  (status, granted_slot,
//                                                     count_after, slot_freed,
//                                                     slots_in_use)
//
// one command at a time: the count memory read takes the cycle after
// the command beat, then the write back and the response register follow.
// busy is high for that one read cycle; done is registered from stage 1.
// reset clears the used bitmap and counter; counts of free slots read as zero.
// the response cannot be stalled.
module refcounted_slot_allocator #(
	parameter int POOL_SLOTS = rsa_pkg::POOL_SLOTS_DEF,
	parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rsa_pkg::cmd_t cmd,
	output logic          done,
	output rsa_pkg::rsp_t rsp
);

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int UW = $clog2(POOL_SLOTS + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic              accept;
	logic [SW-1:0]     cmd_idx;
	logic              in_range;
	logic              chk_used;
	logic [SW-1:0]     free_idx;
	logic              any_free;
	logic [UW-1:0]     used_q;
	logic [UW-1:0]     used_next;

	// stage 1 registers
	logic              vld_s1;
	logic [1:0]        kind_s1;
	logic [2:0]        slot_s1;
	logic [SW-1:0]     idx_s1;
	logic              hit_s1;
	logic              any_free_s1;
	logic [SW-1:0]     free_idx_s1;

	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  wr_en;
	logic [SW-1:0]         wr_idx;
	logic [COUNT_BITS-1:0] wr_data;
	rsa_pkg::map_upd_t     upd;
	rsa_pkg::rsp_t         rsp_d;
	rsa_pkg::rsp_t         rsp_q;
	logic                  done_q;

	// command beat
	assign busy     = vld_s1;
	assign accept   = start && !busy;
	assign cmd_idx  = SW'(cmd.slot);
	assign in_range = 32'(cmd.slot) < 32'(POOL_SLOTS);

	rsa_free_map #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.upd_idx  (wr_idx),
		.chk_idx  (cmd_idx),
		.chk_used (chk_used),
		.free_idx (free_idx),
		.any_free (any_free),
		.used_q   (used_q),
		.used_next(used_next)
	);

	rsa_count_mem #(
		.DEPTH(POOL_SLOTS),
		.WIDTH(COUNT_BITS)
	) u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_data),
		.re   (accept),
		.raddr((cmd.kind == rsa_pkg::KIND_ALLOC) ? free_idx : cmd_idx),
		.rdata(cnt_rd)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= cmd.kind;
			slot_s1     <= cmd.slot;
			idx_s1      <= cmd_idx;
			hit_s1      <= in_range && chk_used;
			any_free_s1 <= any_free;
			free_idx_s1 <= free_idx;
		end
	end

	// count update and response
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = idx_s1;
		wr_data   = cnt_rd;
		upd.alloc = 1'b0;
		upd.free  = 1'b0;
		rsp_d.status       = rsa_pkg::ST_OK;
		rsp_d.granted_slot = slot_s1;
		rsp_d.count_after  = '0;
		rsp_d.slot_freed   = 1'b0;
		unique case (kind_s1)
			rsa_pkg::KIND_ALLOC: begin
				wr_idx             = free_idx_s1;
				rsp_d.granted_slot = '0;
				if (any_free_s1) begin
					wr_en              = vld_s1;
					wr_data            = CNT_ONE;
					upd.alloc          = vld_s1;
					rsp_d.granted_slot = 3'(free_idx_s1);
					rsp_d.count_after  = 8'(CNT_ONE);
				end else begin
					rsp_d.status = rsa_pkg::ST_EXHAUSTED;
				end
			end
			rsa_pkg::KIND_QUERY: begin
				rsp_d.count_after = hit_s1 ? 8'(cnt_rd) : 8'd0;
			end
			rsa_pkg::KIND_ADDREF: begin
				if (!hit_s1) begin
					rsp_d.status = rsa_pkg::ST_NOT_USED;
				end else if (cnt_rd == CNT_MAX) begin
					rsp_d.status      = rsa_pkg::ST_SATURATED;
					rsp_d.count_after = 8'(cnt_rd);
				end else begin
					wr_en             = vld_s1;
					wr_data           = cnt_rd + CNT_ONE;
					rsp_d.count_after = 8'(cnt_rd + CNT_ONE);
				end
			end
			rsa_pkg::KIND_RELEASE: begin
				if (!hit_s1) begin
					rsp_d.status = rsa_pkg::ST_NOT_USED;
				end else if (cnt_rd <= CNT_ONE) begin
					// last reference gone: slot goes back to the pool
					wr_en            = vld_s1;
					wr_data          = '0;
					upd.free         = vld_s1;
					rsp_d.slot_freed = 1'b1;
				end else begin
					wr_en             = vld_s1;
					wr_data           = cnt_rd - CNT_ONE;
					rsp_d.count_after = 8'(cnt_rd - CNT_ONE);
				end
			end
			default: begin
				rsp_d.status = rsa_pkg::ST_OK;
			end
		endcase
		rsp_d.slots_in_use = 4'(used_next);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// one command in flight: read cycle is followed by the response
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done_q && !vld_s1)
		else $error("command overlap or missing response");

	// accepted command always raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after command beat");

	// exhaustion only with a full pool
	a_exhausted_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status == rsa_pkg::ST_EXHAUSTED
		|-> rsp_q.slots_in_use == 4'(POOL_SLOTS))
		else $error("exhausted reported with free slots");

	// used counter never exceeds the pool
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) <= POOL_SLOTS)
		else $error("used counter out of range");
`endif

endmodule
